FILE: sv/svr_pkg.sv
// shared constants, types and constant tables of the sine voice
// no dependencies; used by the interfaces, the sine rom, the top level and the checker

package svr_pkg;

  localparam int SAMPLE_RATE_HZ = 48000;
  localparam int PHASE_BITS     = 32;
  localparam int SINE_DEPTH     = 1024;
  localparam int SAMPLE_BITS    = 16;

  localparam int CMD_W   = 2;
  localparam int NOTE_W  = 7;
  localparam int VEL_W   = 7;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int SMP_W   = 16;
  localparam int LVL_W   = 16;
  localparam int NUM_NOTES = 128;

  localparam int TAB_BITS = $clog2(SINE_DEPTH);
  localparam int SINE_AW  = $clog2(SINE_DEPTH + 1);

  // multiplier operand and product widths
  localparam int MUL_W  = 24;
  localparam int PROD_W = VEL_W + CFG_W;

  // note level = (velocity * gain + 127) / 254, by reciprocal multiply
  localparam int NOTE_DIV    = 254;
  localparam int NOTE_BIAS   = 127;
  localparam int RECIP_SHIFT = 31;
  localparam logic [MUL_W-1:0] RECIP_254 =
      MUL_W'(((64'd1 << RECIP_SHIFT) + NOTE_DIV - 1) / NOTE_DIV);

  localparam logic [31:0]      ROUND_HALF  = 32'd16384;
  localparam logic [LVL_W-1:0] RELEASE_ONE = 16'd32768;

  // dropped low sample bits when the sample width is below 16
  localparam int SMP_DROP = (SAMPLE_BITS < 16) ? (16 - SAMPLE_BITS) : 0;
  localparam logic [SMP_W-1:0] SMP_MASK = SMP_W'(16'hFFFF << SMP_DROP);

  localparam logic [CFG_W-1:0] GAIN_RST   = 16'd9830;
  localparam logic [CFG_W-1:0] DECAY_RST  = 16'd64881;
  localparam logic [CFG_W-1:0] THRESH_RST = 16'd164;

  typedef enum logic [CMD_W-1:0] {
    CMD_NOTE_ON  = 2'd0,
    CMD_NOTE_OFF = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_RSVD     = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN   = 2'd0,
    REG_DECAY  = 2'd1,
    REG_THRESH = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [PHASE_BITS-1:0] phase_acc;
    logic [PHASE_BITS-1:0] phase_step;
    logic [LVL_W-1:0]      note_level;
    logic [LVL_W-1:0]      release_lvl;
    logic                  sounding;
  } voice_t;

  typedef struct packed {
    logic               en;
    logic [SINE_AW-1:0] addr;
  } rom_req_t;

  typedef logic [SMP_W-1:0]      sine_rom_t [0:SINE_DEPTH];
  typedef logic [PHASE_BITS-1:0] step_rom_t [0:NUM_NOTES-1];

  // top octave (notes 116..127) in Hz, Q16.16
  localparam logic [31:0] TOP_OCTAVE [0:11] = '{
    32'd435478539, 32'd461373440, 32'd488808132, 32'd517874176,
    32'd548668578, 32'd581294109, 32'd615859655, 32'd652480576,
    32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013
  };

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] RATE_64 = 64'(SAMPLE_RATE_HZ);

  // quarter-wave sine, Q30 series evaluated at elaboration
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      x  = (PI_Q30 * 64'(i)) / 64'(2 * SINE_DEPTH);
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd156);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
      s  = (x * t) >> 30;
      v  = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      r[i] = SMP_W'(v);
    end
    return r;
  endfunction

  // phase step per midi note for the build sample rate, half rounds up
  function automatic step_rom_t build_step_rom();
    step_rom_t   r;
    int          m;
    int          sh;
    logic [63:0] num;
    logic [63:0] half;
    for (int n = 0; n < NUM_NOTES; n++) begin
      m    = n + 4;
      sh   = 10 - m / 12;
      num  = 64'(TOP_OCTAVE[m % 12]) << (PHASE_BITS - 16);
      half = (RATE_64 << sh) >> 1;
      // divisor rate << sh split into the shift and a divide by the rate
      r[n] = PHASE_BITS'(((num + half) >> sh) / RATE_64);
    end
    return r;
  endfunction

  localparam step_rom_t STEP_ROM = build_step_rom();

endpackage

FILE: sv/svr_if.sv
// handshake channels of the sine voice: input events and output samples
// depends on svr_pkg for field widths

interface svr_in_if import svr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [NOTE_W-1:0] note;
  logic [VEL_W-1:0]  velocity;
  logic              allow_tail;

  modport source (output valid, command, note, velocity, allow_tail, input ready);
  modport sink   (input valid, command, note, velocity, allow_tail, output ready);
endinterface

interface svr_out_if import svr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample_out;
  logic                    voice_active;

  modport source (output valid, sample_out, voice_active, input ready);
  modport sink   (input valid, sample_out, voice_active, output ready);
endinterface

FILE: sv/svr_sine_rom.sv
// quarter-wave sine rom with a registered read
// depends on svr_pkg for the table builder and the request struct

module svr_sine_rom import svr_pkg::*; (
  input  logic             clk,
  input  rom_req_t         req,
  output logic [SMP_W-1:0] data
);

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  always_ff @(posedge clk) begin
    if (req.en) begin
      data <= SINE_ROM[req.addr];
    end
  end

endmodule

FILE: sv/sine_voice_with_release.sv
// one dds sine voice with exponential release, state kept in a one-entry voice memory
// depends on svr_pkg, svr_if and svr_sine_rom
//
// Usage:
//   in_ch carries one event word per handshake: note_on (note, velocity),
//   note_off (allow_tail) or a sample tick. Only ticks return a word on
//   out_ch: the signed sample and whether the voice still sounds.
//   cfg_we/cfg_index/cfg_data write gain, decay and stop threshold; write
//   them while no event is in flight.
// Sequence:
//   every event first reads the voice memory, then goes through one
//   shared 24x24 multiplier, one product per cycle. note_off writes back
//   after the memory read, note_on adds the note level step, an idle tick
//   goes straight to the output load, and a sounding tick runs memory read,
//   sine rom read, level, release, decay, output load. in_ch.ready is high only between events.
// Reset:
//   voice idle, phase and levels zero, registers at their defaults; the
//   memory entry reads as zero until first written.
// Stall:
//   the result sits in an output register; a tick finishing while it is
//   still held waits in its last step until the receiver takes the word.

module sine_voice_with_release import svr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  svr_in_if.sink               in_ch,
  svr_out_if.source            out_ch
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_NLVL = 7'b0000100,
    S_SIN  = 7'b0001000,
    S_REL  = 7'b0010000,
    S_DEC  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] gain_r, decay_r, thresh_r;

  logic [CMD_W-1:0]  cmd_r;
  logic [NOTE_W-1:0] note_r;
  logic [VEL_W-1:0]  vel_r;
  logic              tail_r;

  voice_t voice_mem [0:0];
  voice_t mem_q;
  voice_t voice_rd;
  voice_t mem_wdata;
  logic   mem_we;
  logic   voice_vld_r;

  rom_req_t         rom_req;
  logic [SMP_W-1:0] sine_q;

  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;
  logic [31:0]        rnd_sum;
  logic [LVL_W-1:0]   mag_rnd;
  logic [LVL_W-1:0]   nl_calc;
  logic [LVL_W-1:0]   rel_new;

  logic [PROD_W-1:0] prod_r;
  logic [LVL_W-1:0]  mag_r;
  logic              sign_r;
  logic [SMP_W-1:0]  mag_fin;

  logic [SMP_W-1:0] res_sample_r;
  logic             res_active_r;
  logic             out_valid_r;
  logic [SMP_W-1:0] out_sample_r;
  logic             out_active_r;

  logic in_acc;
  logic out_free;

  logic [1:0]          quad;
  logic [TAB_BITS-1:0] off;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.sample_out   = out_sample_r;
  assign out_ch.voice_active = out_active_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RST;
      decay_r  <= DECAY_RST;
      thresh_r <= THRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN:   gain_r   <= cfg_data;
        REG_DECAY:  decay_r  <= cfg_data;
        REG_THRESH: thresh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // event capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= in_ch.command;
      note_r <= in_ch.note;
      vel_r  <= in_ch.velocity;
      tail_r <= in_ch.allow_tail;
    end
  end

  // voice memory: read on accept; note events write back in their last step, a sounding tick in its decay step
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem_q <= voice_mem[0];
    end
    if (mem_we) begin
      voice_mem[0] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voice_vld_r <= 1'b0;
    end else if (mem_we) begin
      voice_vld_r <= 1'b1;
    end
  end

  assign voice_rd = voice_vld_r ? mem_q : '0;

  // sine rom address from the top phase bits, mirrored in odd quadrants
  assign quad = voice_rd.phase_acc[PHASE_BITS-1 -: 2];
  assign off  = voice_rd.phase_acc[PHASE_BITS-3 -: TAB_BITS];

  always_comb begin
    rom_req.en   = (state_r == S_READ);
    rom_req.addr = quad[0] ? (SINE_AW'(SINE_DEPTH) - SINE_AW'(off)) : SINE_AW'(off);
  end

  svr_sine_rom u_rom (
    .clk  (clk),
    .req  (rom_req),
    .data (sine_q)
  );

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_READ: begin
        mul_a = MUL_W'(vel_r);
        mul_b = MUL_W'(gain_r);
      end
      S_NLVL: begin
        mul_a = MUL_W'(prod_r) + MUL_W'(NOTE_BIAS);
        mul_b = RECIP_254;
      end
      S_SIN: begin
        mul_a = MUL_W'(sine_q);
        mul_b = MUL_W'(voice_rd.note_level);
      end
      S_REL: begin
        mul_a = MUL_W'(mag_r);
        mul_b = MUL_W'(voice_rd.release_lvl);
      end
      S_DEC: begin
        mul_a = MUL_W'(voice_rd.release_lvl);
        mul_b = MUL_W'(decay_r);
      end
      default: ;
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign rnd_sum = 32'(mul_p) + ROUND_HALF;
  assign mag_rnd = rnd_sum[30:15];
  assign nl_calc = mul_p[RECIP_SHIFT +: LVL_W];
  assign rel_new = mul_p[31:16];
  assign mag_fin = mag_r & SMP_MASK;

  // write-back data
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = voice_rd;
    unique case (state_r)
      S_READ: begin
        if (cmd_r == CMD_NOTE_OFF) begin
          mem_we = 1'b1;
          if (tail_r) begin
            if (voice_rd.release_lvl == '0) begin
              mem_wdata.release_lvl = RELEASE_ONE;
            end
          end else begin
            mem_wdata.sounding   = 1'b0;
            mem_wdata.phase_step = '0;
          end
        end
      end
      S_NLVL: begin
        mem_we                = 1'b1;
        mem_wdata.phase_acc   = '0;
        mem_wdata.phase_step  = STEP_ROM[note_r];
        mem_wdata.note_level  = nl_calc;
        mem_wdata.release_lvl = '0;
        mem_wdata.sounding    = 1'b1;
      end
      S_DEC: begin
        mem_we              = 1'b1;
        mem_wdata.phase_acc = voice_rd.phase_acc + voice_rd.phase_step;
        if (voice_rd.release_lvl != '0) begin
          mem_wdata.release_lvl = rel_new;
          if (rel_new <= thresh_r) begin
            mem_wdata.sounding   = 1'b0;
            mem_wdata.phase_step = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_READ: begin
        prod_r       <= mul_p[PROD_W-1:0];
        sign_r       <= quad[1];
        res_sample_r <= '0;
        res_active_r <= 1'b0;
      end
      S_SIN: begin
        mag_r <= mag_rnd;
      end
      S_REL: begin
        if (voice_rd.release_lvl != '0) begin
          mag_r <= mag_rnd;
        end
      end
      S_DEC: begin
        res_sample_r <= sign_r ? (~mag_fin + SMP_W'(1)) : mag_fin;
        res_active_r <= mem_wdata.sounding;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.valid && out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_sample_r <= res_sample_r;
      out_active_r <= res_active_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_READ;
      S_READ: begin
        case (cmd_r)
          CMD_NOTE_ON: state_nxt = S_NLVL;
          CMD_TICK:    state_nxt = voice_rd.sounding ? S_SIN : S_OUT;
          default:     state_nxt = S_IDLE;
        endcase
      end
      S_NLVL: state_nxt = S_IDLE;
      S_SIN:  state_nxt = S_REL;
      S_REL:  state_nxt = S_DEC;
      S_DEC:  state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/svr_checker.sv
// port-level checks of the sine voice, attached to the top level by bind
// depends on svr_pkg for command codes and widths

module svr_checker import svr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [CMD_W-1:0]  in_command,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SMP_W-1:0]  out_sample,
  input logic              out_active
);

  // one event at a time: ready drops right after a word is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while previous event still in work");

  // a result appears only while the input side is busy
  a_result_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared with input side idle");

  // non-tick events (notes and the reserved code) never produce a result right after acceptance
  a_note_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_command != CMD_TICK) |=> !$rose(out_valid))
    else $error("note event produced a result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_sample) && $stable(out_active))
    else $error("stalled result word changed");

endmodule

bind sine_voice_with_release svr_checker u_svr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_command (in_ch.command),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.sample_out),
  .out_active (out_ch.voice_active)
);
